/* hdl/tlf_pkg.sv */
// ----------------------------------------------------------------------------
// tlf_pkg - shared definitions for the text line folder
// Character codes, widths, reset values and the command and status records
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tlf_pkg;

    localparam int CHAR_W           = 8;
    localparam int FW_W             = 6;
    localparam int LINE_CAP_DEFAULT = 32;
    localparam int TAB_STOP         = 8;
    localparam int TAB_MASK         = TAB_STOP - 1;

    localparam logic [FW_W-1:0]   FOLD_WIDTH_RESET = 6'd10;
    localparam logic [CHAR_W-1:0] CH_TAB           = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL            = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SP            = 8'd32;

    // source of the character loaded into the output register
    typedef enum logic [1:0] {
        SEL_FIRST,
        SEL_WORD,
        SEL_P1
    } tlf_sel_t;

    typedef struct packed {
        logic     accept;
        logic     load;
        tlf_sel_t sel;
        logic     last;
    } tlf_cmd_t;

    typedef struct packed {
        logic first_valid;
        logic p1_valid;
        logic slot_free;
    } tlf_status_t;

endpackage

/* hdl/text_line_folder_top.sv */
// ----------------------------------------------------------------------------
// text_line_folder_top - character stream line folder
// Folds a byte stream so that no output line passes the programmed width.
// ----------------------------------------------------------------------------
// s_* carries one character per transfer: s_tdata is the byte (9 tab,
// 10 newline, 32 space), s_tuser the end-of-text flag, which flushes the
// held blank and word and returns the column to zero. m_* carries the
// folded text; m_tlast marks the final transfer caused by one character.
// cfg_wr_en / cfg_wr_data write the fold width (1..LINE_CAP used; 0 acts
// as 1, larger values as LINE_CAP); write only while the block is idle.
// A character that is held or passed straight through needs no drain,
// so plain text flows at one transfer a cycle while m_tready is high.
// A release or fold sends the first byte, then each held word character
// (at most LINE_CAP - 1, as the held blank uses a column), then any
// trailing byte; input is held off until that drain is done.
// Output appears in the cycle after acceptance.
// Reset empties the hold, clears the column and sets the width to 10.
// When m_tready is low the output register holds its transfer and input
// is not accepted until the register can take the next byte.
// ----------------------------------------------------------------------------
module text_line_folder_top #(
    parameter int LINE_CAP = tlf_pkg::LINE_CAP_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [tlf_pkg::FW_W-1:0]    cfg_wr_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tlf_pkg::CHAR_W-1:0]  s_tdata,   // [7:0] in_char
    input  logic                        s_tuser,   // [0] end_of_text
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tlf_pkg::CHAR_W-1:0]  m_tdata,   // [7:0] out_char
    output logic                        m_tlast    // last_of_run
);

    localparam int WL_W  = $clog2(LINE_CAP + 1);
    localparam int IDX_W = $clog2(LINE_CAP);

    tlf_pkg::tlf_cmd_t    cmd;
    tlf_pkg::tlf_status_t status;
    logic [WL_W-1:0]      word_len;
    logic [IDX_W-1:0]     rd_addr;

    tlf_controller #(
        .LINE_CAP (LINE_CAP),
        .WL_W     (WL_W),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .word_len (word_len),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    tlf_datapath #(
        .LINE_CAP (LINE_CAP),
        .WL_W     (WL_W),
        .IDX_W    (IDX_W)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .status      (status),
        .word_len    (word_len)
    );

endmodule

/* hdl/tlf_datapath.sv */
// ----------------------------------------------------------------------------
// tlf_datapath - line folder datapath
// Holds the fold width, column, held blank and word store, decodes each
// input character and drives the output register on controller command.
// ----------------------------------------------------------------------------
module tlf_datapath #(
    parameter int LINE_CAP = tlf_pkg::LINE_CAP_DEFAULT,
    parameter int WL_W     = $clog2(LINE_CAP + 1),
    parameter int IDX_W    = $clog2(LINE_CAP)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [tlf_pkg::FW_W-1:0]    cfg_wr_data,
    input  logic [tlf_pkg::CHAR_W-1:0]  s_tdata,
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tlf_pkg::CHAR_W-1:0]  m_tdata,
    output logic                        m_tlast,
    input  tlf_pkg::tlf_cmd_t           cmd,
    input  logic [IDX_W-1:0]            rd_addr,
    output tlf_pkg::tlf_status_t        status,
    output logic [WL_W-1:0]             word_len
);

    localparam int COL_W = $clog2(LINE_CAP + 10);
    localparam int CMP_W = (COL_W > tlf_pkg::FW_W) ? COL_W : tlf_pkg::FW_W;

    logic [tlf_pkg::FW_W-1:0]   fold_width_reg;
    logic [COL_W-1:0]           column_reg, column_next;
    logic                       blank_held_reg, blank_held_next;
    logic                       tab_held_reg, tab_held_next;
    logic [WL_W-1:0]            word_len_reg, word_len_next;
    logic [tlf_pkg::CHAR_W-1:0] word_mem [LINE_CAP];
    logic [tlf_pkg::CHAR_W-1:0] rd_data_reg;
    logic [tlf_pkg::CHAR_W-1:0] p1_char_reg;
    logic                       m_tvalid_reg;
    logic [tlf_pkg::CHAR_W-1:0] m_tdata_reg;
    logic                       m_tlast_reg;

    logic [CMP_W-1:0]           fw_ext;
    logic [CMP_W-1:0]           width_lim;
    logic [COL_W-1:0]           nc;
    logic                       fits;
    logic                       is_tab, is_blank, is_nl;
    logic                       word_full;
    logic [tlf_pkg::CHAR_W-1:0] held_char;
    logic                       first_valid, p1_valid, wr_en;
    logic [tlf_pkg::CHAR_W-1:0] first_char, p1_char, load_char;
    logic [WL_W-1:0]            drain_len;

    // clamp the width into 1..LINE_CAP
    always_comb
    begin
        fw_ext = CMP_W'(fold_width_reg);
        if (fw_ext == '0)
            width_lim = CMP_W'(1);
        else if (fw_ext > CMP_W'(LINE_CAP))
            width_lim = CMP_W'(LINE_CAP);
        else
            width_lim = fw_ext;
    end

    assign is_tab    = (s_tdata == tlf_pkg::CH_TAB);
    assign is_nl     = (s_tdata == tlf_pkg::CH_NL);
    assign is_blank  = is_tab || (s_tdata == tlf_pkg::CH_SP);
    assign nc        = is_tab ? ((column_reg | COL_W'(tlf_pkg::TAB_MASK)) + COL_W'(1))
                              : (column_reg + COL_W'(1));
    assign fits      = (CMP_W'(nc) <= width_lim);
    assign word_full = (word_len_reg == WL_W'(LINE_CAP));
    assign held_char = tab_held_reg ? tlf_pkg::CH_TAB : tlf_pkg::CH_SP;

    always_comb
    begin
        first_valid     = 1'b0;
        first_char      = s_tdata;
        p1_valid        = 1'b0;
        p1_char         = tlf_pkg::CH_NL;
        drain_len       = '0;
        wr_en           = 1'b0;
        column_next     = column_reg;
        blank_held_next = blank_held_reg;
        tab_held_next   = tab_held_reg;
        word_len_next   = word_len_reg;
        priority if (s_tuser)
        begin
            first_valid     = blank_held_reg;
            first_char      = held_char;
            drain_len       = word_len_reg;
            column_next     = '0;
            blank_held_next = 1'b0;
            tab_held_next   = 1'b0;
            word_len_next   = '0;
        end
        else if (is_nl || (is_blank && !fits))
        begin
            // release the hold, then end the line
            first_valid     = 1'b1;
            first_char      = blank_held_reg ? held_char : tlf_pkg::CH_NL;
            p1_valid        = blank_held_reg;
            drain_len       = word_len_reg;
            column_next     = '0;
            blank_held_next = 1'b0;
            tab_held_next   = 1'b0;
            word_len_next   = '0;
        end
        else if (is_blank)
        begin
            first_valid     = blank_held_reg;
            first_char      = held_char;
            drain_len       = word_len_reg;
            column_next     = nc;
            blank_held_next = 1'b1;
            tab_held_next   = is_tab;
            word_len_next   = '0;
        end
        else if (fits)
        begin
            if (blank_held_reg && !word_full)
            begin
                wr_en         = 1'b1;
                word_len_next = word_len_reg + WL_W'(1);
            end
            else
            begin
                first_valid = 1'b1;
            end
            column_next = nc;
        end
        else
        begin
            // fold: newline in place of the blank, or forced before the character
            first_valid     = 1'b1;
            first_char      = tlf_pkg::CH_NL;
            p1_valid        = 1'b1;
            p1_char         = s_tdata;
            drain_len       = blank_held_reg ? word_len_reg : '0;
            column_next     = blank_held_reg ? (COL_W'(word_len_reg) + COL_W'(1))
                                             : COL_W'(1);
            blank_held_next = 1'b0;
            tab_held_next   = 1'b0;
            word_len_next   = '0;
        end
    end

    always_comb
    begin
        unique case (cmd.sel)
            tlf_pkg::SEL_FIRST: load_char = first_char;
            tlf_pkg::SEL_WORD:  load_char = rd_data_reg;
            tlf_pkg::SEL_P1:    load_char = p1_char_reg;
            default:            load_char = first_char;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_width_reg <= tlf_pkg::FOLD_WIDTH_RESET;
            column_reg     <= '0;
            blank_held_reg <= 1'b0;
            tab_held_reg   <= 1'b0;
            word_len_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                fold_width_reg <= cfg_wr_data;
            if (cmd.accept)
            begin
                column_reg     <= column_next;
                blank_held_reg <= blank_held_next;
                tab_held_reg   <= tab_held_next;
                word_len_reg   <= word_len_next;
            end
            if (cmd.load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            m_tdata_reg <= load_char;
            m_tlast_reg <= cmd.last;
        end
        if (cmd.accept)
            p1_char_reg <= p1_char;
    end

    // word store: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
            word_mem[word_len_reg[IDX_W-1:0]] <= s_tdata;
        rd_data_reg <= word_mem[rd_addr];
    end

    assign m_tvalid           = m_tvalid_reg;
    assign m_tdata            = m_tdata_reg;
    assign m_tlast            = m_tlast_reg;
    assign word_len           = drain_len;
    assign status.first_valid = first_valid;
    assign status.p1_valid    = p1_valid;
    assign status.slot_free   = !m_tvalid_reg || m_tready;

    a_word_needs_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (word_len_reg != '0) |-> blank_held_reg)
        else $error("word characters held without a held blank");

    a_word_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        word_len_reg <= WL_W'(LINE_CAP))
        else $error("word length beyond store depth");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten before transfer");

endmodule

/* hdl/tlf_controller.sv */
// ----------------------------------------------------------------------------
// tlf_controller - line folder sequencer
// Accepts one character when idle, then drains the held word and the
// trailing character into the output register one transfer a cycle while it is free.
// ----------------------------------------------------------------------------
module tlf_controller #(
    parameter int LINE_CAP = tlf_pkg::LINE_CAP_DEFAULT,
    parameter int WL_W     = $clog2(LINE_CAP + 1),
    parameter int IDX_W    = $clog2(LINE_CAP)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  tlf_pkg::tlf_status_t  status,
    input  logic [WL_W-1:0]       word_len,
    output tlf_pkg::tlf_cmd_t     cmd,
    output logic [IDX_W-1:0]      rd_addr
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORD,
        ST_POST
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [WL_W-1:0]  len_reg, len_next;
    logic             p1_pend_reg, p1_pend_next;
    logic             word_done;

    assign word_done = ((WL_W'(idx_reg) + WL_W'(1)) == len_reg);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        len_next     = len_reg;
        p1_pend_next = p1_pend_reg;
        s_tready     = 1'b0;
        rd_addr      = '0;
        cmd.accept   = 1'b0;
        cmd.load     = 1'b0;
        cmd.sel      = tlf_pkg::SEL_FIRST;
        cmd.last     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = status.slot_free;
                if (s_tvalid && status.slot_free)
                begin
                    cmd.accept   = 1'b1;
                    cmd.load     = status.first_valid;
                    cmd.last     = (word_len == '0) && !status.p1_valid;
                    idx_next     = '0;
                    len_next     = word_len;
                    p1_pend_next = status.p1_valid;
                    if (word_len != '0)
                        state_next = ST_WORD;
                    else if (status.p1_valid)
                        state_next = ST_POST;
                end
            end
            ST_WORD:
            begin
                rd_addr = idx_reg;
                if (status.slot_free)
                begin
                    cmd.load = 1'b1;
                    cmd.sel  = tlf_pkg::SEL_WORD;
                    cmd.last = word_done && !p1_pend_reg;
                    idx_next = idx_reg + IDX_W'(1);
                    // read ahead so the next entry is ready next cycle
                    rd_addr  = idx_reg + IDX_W'(1);
                    if (word_done)
                        state_next = p1_pend_reg ? ST_POST : ST_IDLE;
                end
            end
            ST_POST:
            begin
                if (status.slot_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.sel    = tlf_pkg::SEL_P1;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            len_reg     <= '0;
            p1_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            len_reg     <= len_next;
            p1_pend_reg <= p1_pend_next;
        end
    end

    a_word_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WORD) |-> (len_reg != '0))
        else $error("drain started with an empty word");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WORD) |-> (WL_W'(idx_reg) < len_reg))
        else $error("word index past drain length");

    a_post_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POST) |-> p1_pend_reg)
        else $error("trailing transfer without a pending character");

endmodule
